// ----- rtl/core/sgig_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgig_pkg
// Shared types, widths and helpers of the stitched grid index generator.
// ----------------------------------------------------------------------------
package sgig_pkg;

	localparam int FACE_W         = 8;
	localparam int BLOCK_W        = 14;
	localparam int HALF_W         = 7;
	localparam int VERT_W         = 16;
	localparam int SLOT_W         = 3;
	localparam int STEP_W         = 3;
	localparam int MAX_FACE_COUNT_DEF = 254;
	localparam logic [FACE_W-1:0] FACE_COUNT_RESET = 8'd64;
	localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd7;
	localparam logic [2:0] FACE_PAD = 3'd4;

	// entry handed from the front end to the triangle sequencer
	typedef struct packed {
		logic              bad;
		logic [HALF_W-1:0] brow;
		logic [HALF_W-1:0] bcol;
	} sgig_entry_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_DONE
	} front_state_t;

	typedef enum logic [1:0] {
		FC_NORMAL,
		FC_TOP_EVEN,
		FC_LEFT_EVEN,
		FC_ODD
	} face_class_t;

	// Kind of a face inside a block: face 0 top-left .. face 3 bottom-right
	function automatic face_class_t face_class(input logic [1:0] face,
		input logic row0, input logic col0);
		face_class_t cls;
		unique case (face)
			2'd0: begin
				if (col0) cls = FC_LEFT_EVEN;
				else if (row0) cls = FC_TOP_EVEN;
				else cls = FC_NORMAL;
			end
			2'd1: cls = row0 ? FC_ODD : FC_NORMAL;
			2'd2: cls = col0 ? FC_ODD : FC_NORMAL;
			default: cls = FC_NORMAL;
		endcase
		return cls;
	endfunction

endpackage

// ----- rtl/core/sgig_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgig_front
// Accepts block numbers, flags out-of-range blocks and splits the number
// into block row and column with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module sgig_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sgig_pkg::BLOCK_W-1:0] block_index,
	input  logic [sgig_pkg::HALF_W-1:0]  half,
	output logic                         push_valid,
	input  logic                         push_ready,
	output sgig_pkg::sgig_entry_t        push_entry
);
	import sgig_pkg::*;

	front_state_t state_q, state_d;
	logic [BLOCK_W-1:0] rem_q;
	logic [HALF_W-1:0]  quot_q;
	logic [STEP_W-1:0]  step_q;
	logic               bad_q;

	logic               accept;
	logic [BLOCK_W-1:0] div_sub;
	logic               div_ge;
	logic [BLOCK_W-1:0] half_sq;
	logic               first_step;
	logic               out_of_range;

	assign accept       = s_tvalid && s_tready;
	assign div_sub      = BLOCK_W'(half) << step_q;
	assign div_ge       = rem_q >= div_sub;
	assign half_sq      = BLOCK_W'(half) * BLOCK_W'(half);
	assign first_step   = step_q == STEP_W'(HALF_W - 1);
	assign out_of_range = (half == '0) || (rem_q >= half_sq);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) state_d = FS_DIV;
			end
			FS_DIV: begin
				if ((first_step && out_of_range) || step_q == '0) state_d = FS_DONE;
			end
			FS_DONE: begin
				if (push_ready) state_d = accept ? FS_DIV : FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			FS_IDLE: s_tready = 1'b1;
			FS_DIV:  s_tready = 1'b0;
			FS_DONE: begin
				s_tready   = push_ready;
				push_valid = 1'b1;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= block_index;
			quot_q <= '0;
			step_q <= STEP_W'(HALF_W - 1);
			bad_q  <= 1'b0;
		end else if (state_q == FS_DIV) begin
			if (div_ge) rem_q <= rem_q - div_sub;
			quot_q <= {quot_q[HALF_W-2:0], div_ge};
			step_q <= step_q - STEP_W'(1);
			if (first_step) bad_q <= out_of_range;
		end
	end

	assign push_entry.bad  = bad_q;
	assign push_entry.brow = quot_q;
	assign push_entry.bcol = rem_q[HALF_W-1:0];

endmodule

// ----- rtl/core/sgig_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgig_queue
// Two-entry queue between the front end and the triangle sequencer.
// ----------------------------------------------------------------------------
module sgig_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  sgig_pkg::sgig_entry_t push_entry,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output sgig_pkg::sgig_entry_t pop_entry
);
	import sgig_pkg::*;

	sgig_entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ----- rtl/core/sgig_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgig_back
// Turns a block row and column into eight stitched, padded triangles or one
// flagged item for a bad block, registered, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module sgig_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sgig_pkg::FACE_W-1:0]   fc,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  sgig_pkg::sgig_entry_t         pop_entry,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [3*sgig_pkg::VERT_W-1:0] m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);
	import sgig_pkg::*;

	// stage 1: top-left vertex of the block
	logic              valid_s1;
	logic              bad_s1;
	logic              row0_s1;
	logic              col0_s1;
	logic [VERT_W-1:0] tl0_s1;

	// triangle sequencer
	logic              gen_valid_q;
	logic              bad_q;
	logic              row0_q;
	logic              col0_q;
	logic [VERT_W-1:0] tl0_q;
	logic [2:0]        face_q;
	logic              sub_q;
	logic [SLOT_W-1:0] slot_q;

	logic [FACE_W-1:0]   s8;
	logic [VERT_W-1:0]   stride;
	logic [FACE_W-1:0]   row2;
	logic [FACE_W-1:0]   col2;
	logic [VERT_W-1:0]   prod;
	logic                out_free;
	logic                emit;
	logic                gen_last;
	logic                gen_free;
	logic                gen_load;
	face_class_t         cls;
	logic                one_tri;
	logic [VERT_W-1:0]   face_off;
	logic [VERT_W-1:0]   tl;
	logic [VERT_W-1:0]   bl;
	logic [VERT_W-1:0]   va, vb, vc;

	assign s8     = fc + FACE_W'(1);
	assign stride = VERT_W'(s8);
	assign row2   = {pop_entry.brow, 1'b0};
	assign col2   = {pop_entry.bcol, 1'b0};
	assign prod   = VERT_W'(row2) * VERT_W'(s8);

	assign out_free  = !m_tvalid || m_tready;
	assign emit      = gen_valid_q && out_free;
	assign gen_last  = bad_q || slot_q == LAST_SLOT;
	assign gen_free  = !gen_valid_q || (emit && gen_last);
	assign gen_load  = valid_s1 && gen_free;
	assign pop_ready = !valid_s1 || gen_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop_valid && pop_ready) begin
			valid_s1 <= 1'b1;
		end else if (gen_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			bad_s1  <= pop_entry.bad;
			row0_s1 <= pop_entry.brow == '0;
			col0_s1 <= pop_entry.bcol == '0;
			tl0_s1  <= prod + VERT_W'(col2);
		end
	end

	assign cls     = face_class(face_q[1:0], row0_q, col0_q);
	assign one_tri = cls == FC_ODD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_valid_q <= 1'b0;
			face_q      <= '0;
			sub_q       <= 1'b0;
			slot_q      <= '0;
		end else if (gen_load) begin
			gen_valid_q <= 1'b1;
			face_q      <= '0;
			sub_q       <= 1'b0;
			slot_q      <= '0;
		end else if (emit && gen_last) begin
			gen_valid_q <= 1'b0;
		end else if (emit) begin
			slot_q <= slot_q + SLOT_W'(1);
			// move to the next face once its triangles are out; stay in padding
			if (face_q != FACE_PAD) begin
				if (sub_q || one_tri) begin
					face_q <= face_q + 3'd1;
					sub_q  <= 1'b0;
				end else begin
					sub_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_load) begin
			bad_q  <= bad_s1;
			row0_q <= row0_s1;
			col0_q <= col0_s1;
			tl0_q  <= tl0_s1;
		end
	end

	always_comb begin
		unique case (face_q[1:0])
			2'd0: face_off = '0;
			2'd1: face_off = VERT_W'(1);
			2'd2: face_off = stride;
			default: face_off = stride + VERT_W'(1);
		endcase
	end

	assign tl = tl0_q + face_off;
	assign bl = tl + stride;

	always_comb begin
		va = '0;
		vb = '0;
		vc = '0;
		if (!bad_q && face_q != FACE_PAD) begin
			unique case (cls)
				FC_LEFT_EVEN: begin
					va = tl;
					vc = bl + VERT_W'(1);
					if (!sub_q) vb = tl + {stride[VERT_W-2:0], 1'b0};
					else if (row0_q && face_q[1:0] == 2'd0) vb = tl + VERT_W'(2);
					else vb = tl + VERT_W'(1);
				end
				FC_TOP_EVEN: begin
					va = tl;
					vb = sub_q ? bl : tl + VERT_W'(2);
					vc = bl + VERT_W'(1);
				end
				FC_ODD: begin
					va = tl + VERT_W'(1);
					vb = bl;
					vc = bl + VERT_W'(1);
				end
				default: begin
					va = sub_q ? tl + VERT_W'(1) : tl;
					vb = sub_q ? bl : tl + VERT_W'(1);
					vc = sub_q ? bl + VERT_W'(1) : bl;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= {vc, vb, va};
			m_tlast <= gen_last;
			m_tuser <= bad_q;
		end
	end

endmodule

// ----- rtl/core/stitched_grid_index_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stitched_grid_index_generator
// Expands 2x2 block numbers of a square face grid into eight triangles of
// vertex indices each, stitched coarser along the top and left edges.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata[13:0] block_index
//  m_*      | out       | tdata vertex_a/b/c, tlast last_of_block, tuser bad_block
//  cfg_*    | in        | cfg_wr_data face_count, written when cfg_wr_en is high
//
// A block in range gives 8 items, one per cycle while the output accepts them;
// the front end divides the block number in 7 steps and takes no new block
// until it has handed the last one on. An out-of-range block gives one item.
// Reset clears all control state and sets face_count to 64.
// Either side may stall; a two-entry queue separates divider and sequencer.
// ----------------------------------------------------------------------------
module stitched_grid_index_generator #(
	parameter int MAX_FACE_COUNT = sgig_pkg::MAX_FACE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,      // [13:0] block_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [3*sgig_pkg::VERT_W-1:0] m_tdata,      // vertex_a, vertex_b, vertex_c
	output logic                          m_tlast,      // last_of_block
	output logic                          m_tuser,      // bad_block
	input  logic                          cfg_wr_en,
	input  logic [sgig_pkg::FACE_W-1:0]   cfg_wr_data   // face_count
);
	import sgig_pkg::*;

	logic [FACE_W-1:0] face_count_q;
	logic [FACE_W-1:0] fc_even;
	logic [FACE_W-1:0] fc_eff;
	logic [HALF_W-1:0] half;

	logic        push_valid;
	logic        push_ready;
	sgig_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	sgig_entry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q <= FACE_COUNT_RESET;
		end else if (cfg_wr_en) begin
			face_count_q <= cfg_wr_data;
		end
	end

	// drop the low bit, then clamp to the supported size
	assign fc_even = {face_count_q[FACE_W-1:1], 1'b0};
	assign fc_eff  = (fc_even > FACE_W'(MAX_FACE_COUNT)) ? FACE_W'(MAX_FACE_COUNT) : fc_even;
	assign half    = fc_eff[FACE_W-1:1];

	sgig_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.block_index (s_tdata[BLOCK_W-1:0]),
		.half        (half),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	sgig_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	sgig_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fc        (fc_eff),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTHESIS
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("flagged item without tlast");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("flagged item carries vertices");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front end took two items in a row");
`endif

endmodule

// ----- tb/sv/stitched_grid_index_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stitched_grid_index_generator_tb
// Feeds block numbers to the grid index generator under several face counts
// and checks every triangle item against an in-bench predictor. Both stream
// sides idle at random; reset default, tiny, empty, odd and largest grids are
// covered before the random phases.
// ----------------------------------------------------------------------------
module stitched_grid_index_generator_tb;

	import sgig_pkg::*;

	localparam int          MAX_FACES   = MAX_FACE_COUNT_DEF;
	localparam int          BLOCKS_TOP  = 16383;
	localparam int          SETTLE_CYC  = 20;
	localparam int          CYCLE_LIMIT = 600000;
	localparam int          RAND_PHASE  = 50;

	typedef struct packed {
		logic [VERT_W-1:0] a;
		logic [VERT_W-1:0] b;
		logic [VERT_W-1:0] c;
		logic              last;
		logic              bad;
	} tri_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;      // [13:0] block_index
	logic                  m_tvalid;
	logic                  m_tready;
	logic [3*VERT_W-1:0]   m_tdata;      // vertex_a, vertex_b, vertex_c
	logic                  m_tlast;      // last_of_block
	logic                  m_tuser;      // bad_block
	logic                  cfg_wr_en;
	logic [FACE_W-1:0]     cfg_wr_data;  // face_count

	tri_t                  expected_tris[$];
	tri_t                  block_tris[$];
	logic [FACE_W-1:0]     face_count_reg;
	int                    fail_count;
	int                    cycle_count;
	int                    rx_run;
	bit                    tx_stalls_on;
	bit                    rx_stalls_on;

	stitched_grid_index_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return $urandom_range(1, 3);
		else if (sel < 18)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic int unsigned grid_half();
		int unsigned faces;
		faces = face_count_reg & 8'hFE;
		if (faces > MAX_FACES)
			faces = MAX_FACES;
		return faces / 2;
	endfunction

	function automatic void add_tri(input int unsigned a, input int unsigned b,
		input int unsigned c);
		tri_t t;
		t.a    = 16'(a);
		t.b    = 16'(b);
		t.c    = 16'(c);
		t.last = 1'b0;
		t.bad  = 1'b0;
		block_tris = {block_tris, t};
	endfunction

	// triangles of one face; edge faces stitch to coarser neighbors
	function automatic void add_face(input int unsigned f, input int unsigned fc);
		int unsigned tl, bl;
		tl = f + f / fc;
		bl = tl + fc + 1;
		if (f % fc == 0) begin
			if (f % (2 * fc) == 0) begin
				add_tri(tl, tl + 2 * (fc + 1), bl + 1);
				if (f == 0)
					add_tri(tl, tl + 2, bl + 1);
				else
					add_tri(tl, tl + 1, bl + 1);
			end else begin
				add_tri(tl + 1, bl, bl + 1);
			end
		end else if (f < fc) begin
			if (f % 2 == 0) begin
				add_tri(tl, tl + 2, bl + 1);
				add_tri(tl, bl, bl + 1);
			end else begin
				add_tri(tl + 1, bl, bl + 1);
			end
		end else begin
			add_tri(tl, tl + 1, bl);
			add_tri(tl + 1, bl, bl + 1);
		end
	endfunction

	function automatic void predict_block(input logic [BLOCK_W-1:0] blk);
		int unsigned half, fc, base;
		tri_t t;
		half = grid_half();
		fc   = half * 2;
		if (half == 0 || blk >= half * half) begin
			t = '0;
			t.last = 1'b1;
			t.bad  = 1'b1;
			expected_tris = {expected_tris, t};
			return;
		end
		block_tris.delete();
		base = (blk / half) * fc * 2 + (blk % half) * 2;
		add_face(base, fc);
		add_face(base + 1, fc);
		add_face(base + fc, fc);
		add_face(base + fc + 1, fc);
		while (block_tris.size() < 8)
			add_tri(0, 0, 0);
		block_tris[7].last = 1'b1;
		foreach (block_tris[i])
			expected_tris = {expected_tris, block_tris[i]};
	endfunction

	// bias toward the stitched edges and the last block of the grid
	function automatic logic [BLOCK_W-1:0] pick_block();
		int unsigned half, sel;
		half = grid_half();
		sel  = $urandom_range(0, 99);
		if (half == 0 || sel < 12)
			return 14'($urandom_range(0, BLOCKS_TOP));
		if (sel < 24)
			return 14'($urandom_range(0, half - 1));
		if (sel < 36)
			return 14'($urandom_range(0, half - 1) * half);
		if (sel < 40)
			return 14'(half * half - 1);
		return 14'($urandom_range(0, half * half - 1));
	endfunction

	task automatic send_block(input logic [BLOCK_W-1:0] blk);
		int gap;
		gap = 0;
		if (tx_stalls_on && $urandom_range(0, 9) >= 6)
			gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, blk};
		predict_block(blk);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic pause_for_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_tris.size() != 0);
	endtask

	task automatic wait_idle();
		pause_for_results();
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_face_count(input logic [FACE_W-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en      <= 1'b0;
		face_count_reg  = value;
	endtask

	// receiver: ready in runs, with random stalls between them
	always @(posedge clk) begin
		if (rx_run == 0) begin
			if (!rx_stalls_on || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				rx_run    = $urandom_range(1, 16);
			end else begin
				m_tready <= 1'b0;
				rx_run    = idle_len();
			end
		end else begin
			rx_run--;
		end
	end

	always @(posedge clk) begin
		tri_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.a    = m_tdata[VERT_W-1:0];
			got.b    = m_tdata[2*VERT_W-1:VERT_W];
			got.c    = m_tdata[3*VERT_W-1:2*VERT_W];
			got.last = m_tlast;
			got.bad  = m_tuser;
			if (expected_tris.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected item a=%0d b=%0d c=%0d last=%0b bad=%0b",
					$time, got.a, got.b, got.c, got.last, got.bad);
			end else begin
				want = expected_tris.pop_front();
				if (got !== want) begin
					fail_count++;
					$display("%0t: mismatch expected a=%0d b=%0d c=%0d last=%0b bad=%0b",
						$time, want.a, want.b, want.c, want.last, want.bad);
					$display("%0t:          actual   a=%0d b=%0d c=%0d last=%0b bad=%0b",
						$time, got.a, got.b, got.c, got.last, got.bad);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// reset value of 64 faces: corner, top and left edges, interior, range end
	task automatic test_reset_grid();
		send_block(14'd0);
		send_block(14'd1);
		send_block(14'd31);
		send_block(14'd32);
		send_block(14'd33);
		send_block(14'd1023);
		send_block(14'd1024);
		send_block(14'd16383);
	endtask

	// smallest grids, an odd count that drops its low bit
	task automatic test_small_grids();
		set_face_count(8'd2);
		send_block(14'd0);
		send_block(14'd1);
		set_face_count(8'd3);
		send_block(14'd0);
		send_block(14'd1);
		set_face_count(8'd4);
		for (int i = 0; i < 5; i++)
			send_block(14'(i));
	endtask

	// zero or one face means no blocks: every item is flagged
	task automatic test_empty_grids();
		set_face_count(8'd0);
		send_block(14'd0);
		send_block(14'd5);
		set_face_count(8'd1);
		send_block(14'd0);
	endtask

	task automatic test_largest_grid();
		set_face_count(8'd255);
		send_block(14'd0);
		send_block(14'd126);
		send_block(14'd127);
		send_block(14'd16128);
		send_block(14'd16129);
	endtask

	task automatic test_random_grids();
		logic [FACE_W-1:0] counts[8];
		counts[0] = 8'd254;
		counts[1] = 8'd2;
		counts[2] = 8'd9;
		counts[3] = 8'($urandom_range(2, 126) * 2);
		counts[4] = 8'($urandom_range(2, 127) * 2 + 1);
		counts[5] = 8'd1;
		counts[6] = 8'd128;
		counts[7] = 8'd255;
		foreach (counts[p]) begin
			set_face_count(counts[p]);
			// one phase runs at full rate on both sides
			tx_stalls_on = (p != 3);
			rx_stalls_on = (p != 3);
			for (int i = 0; i < RAND_PHASE; i++)
				send_block(pick_block());
		end
		tx_stalls_on = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// hold off the sender until the output side has caught up
	task automatic test_drain_pause();
		set_face_count(8'($urandom_range(10, 90)));
		for (int i = 0; i < 40; i++) begin
			if (i % 8 == 7)
				pause_for_results();
			send_block(pick_block());
		end
	endtask

	initial begin
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		m_tready       <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		arst_n         <= 1'b0;
		face_count_reg  = FACE_COUNT_RESET;
		fail_count      = 0;
		cycle_count     = 0;
		rx_run          = 0;
		tx_stalls_on    = 1'b1;
		rx_stalls_on    = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_grid();
		test_small_grids();
		test_empty_grids();
		test_largest_grid();
		test_random_grids();
		test_drain_pause();

		wait_idle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
